// ===== hdl/dpfr_pkg.sv =====
// package for the demand paging fifo replacement unit
// types, sizing constants and status codes; no dependencies
package dpfr_pkg;

	localparam int PageBytesDef = 16;
	localparam int PagesDef     = 64;
	localparam int FramesDef    = 8;

	localparam int VaddrW  = 16;
	localparam int LimitW  = 11;
	localparam int WrPageW = 7;
	localparam int StatusW = 3;
	localparam int FrameW  = 3;
	localparam int OffsetW = 4;
	localparam int PageW   = 6;
	localparam int CfgIdxW = 1;
	localparam int CfgDataW = 11;

	localparam logic [LimitW-1:0]  ExecLimitRst = 11'd1024;
	localparam logic [WrPageW-1:0] WrFromRst    = 7'd32;

	typedef enum logic [StatusW-1:0] {
		ST_HIT      = 3'd0,
		ST_DISK     = 3'd1,
		ST_SWAP     = 3'd2,
		ST_RANGE    = 3'd3,
		ST_READONLY = 3'd4
	} status_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_EXEC_LIMIT = 1'd0,
		REG_WR_FROM    = 1'd1
	} reg_idx_t;

	typedef struct packed {
		logic              action;
		logic [VaddrW-1:0] vaddr;
	} in_word_t;

	typedef struct packed {
		logic [StatusW-1:0] status;
		logic [FrameW-1:0]  frame;
		logic [OffsetW-1:0] offset;
		logic               evicted;
		logic [PageW-1:0]   evicted_page;
		logic               writeback;
	} out_word_t;

endpackage

// ===== hdl/dpfr_front.sv =====
// front part: range and permission check, page/offset split, queue push
// depends on dpfr_pkg
module dpfr_front #(
	parameter int PAGE_BYTES = dpfr_pkg::PageBytesDef,
	parameter int PAGES      = dpfr_pkg::PagesDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  dpfr_pkg::in_word_t            in_word,
	input  logic [dpfr_pkg::LimitW-1:0]   exec_limit,
	input  logic [dpfr_pkg::WrPageW-1:0]  wr_from,
	input  logic                          q_full,
	output logic                          busy,
	output logic                          push_s1,
	output logic                          store_s1,
	output logic [$clog2(PAGES)-1:0]      page_s1,
	output logic [dpfr_pkg::OffsetW-1:0]  offset_s1,
	output dpfr_pkg::status_t             pre_s1
);
	localparam int OffW = $clog2(PAGE_BYTES);
	localparam int PgW  = $clog2(PAGES);

	logic [dpfr_pkg::VaddrW-1:0] page_full;
	logic                        refuse_rng, refuse_ro;

	assign busy = q_full;
	assign page_full = in_word.vaddr >> OffW;
	assign refuse_rng = ({5'd0, exec_limit} <= in_word.vaddr) ||
		(page_full >= dpfr_pkg::VaddrW'(PAGES));
	assign refuse_ro = in_word.action &&
		(page_full < dpfr_pkg::VaddrW'(wr_from));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push_s1 <= 1'b0;
		end else begin
			push_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			store_s1  <= in_word.action;
			page_s1   <= page_full[PgW-1:0];
			offset_s1 <= dpfr_pkg::OffsetW'(in_word.vaddr[OffW-1:0]);
			pre_s1    <= refuse_rng ? dpfr_pkg::ST_RANGE :
				(refuse_ro ? dpfr_pkg::ST_READONLY : dpfr_pkg::ST_HIT);
		end
	end
endmodule

// ===== hdl/dpfr_queue.sv =====
// short fifo between front and back parts
// depends on dpfr_pkg
module dpfr_queue #(
	parameter int PAGES = dpfr_pkg::PagesDef
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic                         store_in,
	input  logic [$clog2(PAGES)-1:0]     page_in,
	input  logic [dpfr_pkg::OffsetW-1:0] offset_in,
	input  dpfr_pkg::status_t            pre_in,
	input  logic                         pop,
	output logic                         full,
	output logic                         not_empty,
	output logic                         store_out,
	output logic [$clog2(PAGES)-1:0]     page_out,
	output logic [dpfr_pkg::OffsetW-1:0] offset_out,
	output dpfr_pkg::status_t            pre_out
);
	localparam int EW = 1 + $clog2(PAGES) + dpfr_pkg::OffsetW + dpfr_pkg::StatusW;

	logic [EW-1:0] ent_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	logic [EW-1:0] rd;

	// entry count of two keeps the front one item ahead of the back
	// a word still in the front register counts against the free space
	assign full = (cnt_q == 2'd2) || ((cnt_q == 2'd1) && push);
	assign not_empty = (cnt_q != 2'd0);
	assign rd = ent_q[rp_q];
	assign store_out = rd[EW-1];
	assign page_out = rd[EW-2 -: $clog2(PAGES)];
	assign offset_out = rd[dpfr_pkg::StatusW +: dpfr_pkg::OffsetW];
	assign pre_out = dpfr_pkg::status_t'(rd[dpfr_pkg::StatusW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= {store_in, page_in, offset_in, pre_in};
		end
	end
endmodule

// ===== hdl/dpfr_back.sv =====
// back part: page table lookup, fifo frame allocation and eviction
// depends on dpfr_pkg
module dpfr_back #(
	parameter int PAGES  = dpfr_pkg::PagesDef,
	parameter int FRAMES = dpfr_pkg::FramesDef
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         valid,
	input  logic                         store,
	input  logic [$clog2(PAGES)-1:0]     page,
	input  logic [dpfr_pkg::OffsetW-1:0] offset,
	input  dpfr_pkg::status_t            pre,
	output logic                         ready,
	output logic                         done,
	output dpfr_pkg::out_word_t          result
);
	localparam int PgW = $clog2(PAGES);
	localparam int FrW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int FcW = $clog2(FRAMES + 1);

	logic [PAGES-1:0]  res_q, wr_q;
	logic [FrW-1:0]    pframe_q [PAGES];
	logic [PgW-1:0]    owner_q [FRAMES];
	logic [FcW-1:0]    filled_q;
	logic [FrW-1:0]    vict_q;

	// word under processing, with its frame table entry read on capture
	logic                         act_s2, store_s2;
	logic [PgW-1:0]               page_s2;
	logic [dpfr_pkg::OffsetW-1:0] offset_s2;
	dpfr_pkg::status_t            pre_s2;
	logic [FrW-1:0]               pfrm_s2;

	logic              take, refused, hit, full_f;
	logic [FrW-1:0]    frame_c, next_v;
	logic [PgW-1:0]    owner;

	// each word: capture and table read, then resolve and update; ready only when idle
	assign ready = !act_s2;
	assign take = valid && !act_s2;

	assign refused = (pre_s2 != dpfr_pkg::ST_HIT);
	assign hit = res_q[page_s2];
	assign full_f = (filled_q == FcW'(FRAMES));
	assign owner = owner_q[vict_q];
	assign frame_c = hit ? pfrm_s2 : (full_f ? vict_q : FrW'(filled_q));
	assign next_v = (vict_q == FrW'(FRAMES - 1)) ? '0 : vict_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s2   <= 1'b0;
			res_q    <= '0;
			wr_q     <= '0;
			filled_q <= '0;
			vict_q   <= '0;
			done     <= 1'b0;
		end else begin
			act_s2 <= take;
			done   <= act_s2;
			if (act_s2 && !refused) begin
				if (!hit) begin
					if (full_f) begin
						res_q[owner] <= 1'b0;
						vict_q <= next_v;
					end else begin
						filled_q <= filled_q + 1'b1;
					end
					res_q[page_s2] <= 1'b1;
				end
				if (store_s2) wr_q[page_s2] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			store_s2  <= store;
			page_s2   <= page;
			offset_s2 <= offset;
			pre_s2    <= pre;
			pfrm_s2   <= pframe_q[page];
		end
	end

	always_ff @(posedge clk) begin
		if (act_s2 && !refused && !hit) begin
			owner_q[frame_c]  <= page_s2;
			pframe_q[page_s2] <= frame_c;
		end
	end

	always_ff @(posedge clk) begin
		if (act_s2) begin
			result.offset       <= offset_s2;
			result.status       <= refused ? pre_s2 :
				(hit ? dpfr_pkg::ST_HIT :
				(wr_q[page_s2] ? dpfr_pkg::ST_SWAP : dpfr_pkg::ST_DISK));
			result.frame        <= refused ? '0 : dpfr_pkg::FrameW'(frame_c);
			result.evicted      <= !refused && !hit && full_f;
			result.evicted_page <= (!refused && !hit && full_f) ?
				dpfr_pkg::PageW'(owner) : '0;
			result.writeback    <= !refused && !hit && full_f && wr_q[owner];
		end
	end
endmodule

// ===== hdl/demand_paging_fifo_replacement_unit.sv =====
// top level of the demand paging fifo replacement unit
// depends on dpfr_pkg, dpfr_front, dpfr_queue, dpfr_back
//
// A word accepted on start (busy low) gives one result word on done after it
// passes the front register, the queue, the back capture with table read and
// the back result register. The back part takes a new word only once the last
// one is resolved; busy rises while the queue and the front register together
// hold two waiting words. Results cannot be held off.
module demand_paging_fifo_replacement_unit #(
	parameter int PAGE_BYTES = dpfr_pkg::PageBytesDef,
	parameter int PAGES      = dpfr_pkg::PagesDef,
	parameter int FRAMES     = dpfr_pkg::FramesDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  dpfr_pkg::in_word_t            in_word,
	output logic                          done,
	output dpfr_pkg::out_word_t           result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dpfr_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [dpfr_pkg::CfgDataW-1:0] cfg_data
);
	logic [dpfr_pkg::LimitW-1:0]  exec_limit_q;
	logic [dpfr_pkg::WrPageW-1:0] wr_from_q;
	logic                         push_s1, store_s1, q_full, q_ne;
	logic [$clog2(PAGES)-1:0]     page_s1, q_page;
	logic [dpfr_pkg::OffsetW-1:0] offset_s1, q_off;
	dpfr_pkg::status_t            pre_s1, q_pre;
	logic                         q_store;
	logic                         back_rdy;

	// configuration registers, always writable
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exec_limit_q <= dpfr_pkg::ExecLimitRst;
			wr_from_q    <= dpfr_pkg::WrFromRst;
		end else if (cfg_valid) begin
			unique case (dpfr_pkg::reg_idx_t'(cfg_index))
				dpfr_pkg::REG_EXEC_LIMIT: exec_limit_q <= cfg_data;
				dpfr_pkg::REG_WR_FROM:    wr_from_q <= cfg_data[dpfr_pkg::WrPageW-1:0];
				default: ;
			endcase
		end
	end

	dpfr_front #(.PAGE_BYTES(PAGE_BYTES), .PAGES(PAGES)) u_front (
		.clk, .arst_n, .start, .in_word,
		.exec_limit(exec_limit_q), .wr_from(wr_from_q), .q_full,
		.busy, .push_s1, .store_s1, .page_s1, .offset_s1, .pre_s1
	);

	// back part pops the head word whenever it is idle
	dpfr_queue #(.PAGES(PAGES)) u_queue (
		.clk, .arst_n, .push(push_s1), .store_in(store_s1), .page_in(page_s1),
		.offset_in(offset_s1), .pre_in(pre_s1), .pop(q_ne && back_rdy),
		.full(q_full), .not_empty(q_ne), .store_out(q_store),
		.page_out(q_page), .offset_out(q_off), .pre_out(q_pre)
	);

	dpfr_back #(.PAGES(PAGES), .FRAMES(FRAMES)) u_back (
		.clk, .arst_n, .valid(q_ne), .store(q_store), .page(q_page),
		.offset(q_off), .pre(q_pre), .ready(back_rdy), .done, .result
	);

	// refused words carry no frame and no eviction
	a_refused_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == dpfr_pkg::ST_RANGE ||
			result.status == dpfr_pkg::ST_READONLY)
		|-> result.frame == '0 && !result.evicted && !result.writeback)
		else $error("refused word with frame or eviction");

	// writeback only alongside an eviction
	a_wb_evict: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.writeback |-> result.evicted)
		else $error("writeback without eviction");

	// an eviction is always a fault
	a_evict_fault: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.evicted |->
		(result.status == dpfr_pkg::ST_DISK || result.status == dpfr_pkg::ST_SWAP))
		else $error("eviction on non-fault");
endmodule

// ===== bench/dpfr_checker.sv =====
// checker for the demand paging fifo replacement unit
// watches access, result and register channels; depends on dpfr_pkg
module dpfr_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  dpfr_pkg::in_word_t            in_word,
	input  logic                          done,
	input  dpfr_pkg::out_word_t           result,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [dpfr_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [dpfr_pkg::CfgDataW-1:0] cfg_data,
	output int                            errors,
	output int                            outstanding,
	output int                            checked
);

	localparam int NPages  = dpfr_pkg::PagesDef;
	localparam int NFrames = dpfr_pkg::FramesDef;

	logic [dpfr_pkg::LimitW-1:0]  lim_q;
	logic [dpfr_pkg::WrPageW-1:0] wr_from_q;
	logic                         resident [NPages];
	logic [dpfr_pkg::FrameW-1:0]  page_frm [NPages];
	logic                         dirty    [NPages];
	logic [dpfr_pkg::PageW-1:0]   owner    [NFrames];
	int                           n_filled;
	logic [dpfr_pkg::FrameW-1:0]  ring_ptr;
	dpfr_pkg::out_word_t          pending_q[$];

	task automatic report(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
		errors++;
	endtask

	// translation of one access, updating the page and frame tables
	function automatic dpfr_pkg::out_word_t translate(input dpfr_pkg::in_word_t w);
		dpfr_pkg::out_word_t         r;
		logic [15:0]                 pg;
		logic [dpfr_pkg::FrameW-1:0] f;
		r        = '0;
		pg       = w.vaddr >> 4;
		r.offset = w.vaddr[dpfr_pkg::OffsetW-1:0];
		if (w.vaddr >= 16'(lim_q) || pg >= 16'(NPages)) begin
			r.status = dpfr_pkg::ST_RANGE;
		end else if (w.action && pg < 16'(wr_from_q)) begin
			r.status = dpfr_pkg::ST_READONLY;
		end else if (resident[pg]) begin
			r.status = dpfr_pkg::ST_HIT;
			r.frame  = page_frm[pg];
			if (w.action) dirty[pg] = 1'b1;
		end else begin
			r.status = dirty[pg] ? dpfr_pkg::ST_SWAP : dpfr_pkg::ST_DISK;
			if (n_filled < NFrames) begin
				f = dpfr_pkg::FrameW'(n_filled);
				n_filled++;
			end else begin
				f              = ring_ptr;
				r.evicted      = 1'b1;
				r.evicted_page = owner[f];
				r.writeback    = dirty[owner[f]];
				resident[owner[f]] = 1'b0;
				ring_ptr       = ring_ptr + 1'b1;
			end
			r.frame      = f;
			owner[f]     = pg[dpfr_pkg::PageW-1:0];
			page_frm[pg] = f;
			resident[pg] = 1'b1;
			if (w.action) dirty[pg] = 1'b1;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dpfr_pkg::out_word_t e;
		if (!arst_n) begin
			lim_q     = dpfr_pkg::ExecLimitRst;
			wr_from_q = dpfr_pkg::WrFromRst;
			for (int i = 0; i < NPages; i++) begin
				resident[i] = 1'b0;
				page_frm[i] = '0;
				dirty[i]    = 1'b0;
			end
			n_filled  = 0;
			ring_ptr  = '0;
			pending_q = {};
			errors    = 0;
			checked   = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == dpfr_pkg::REG_EXEC_LIMIT)
					lim_q = cfg_data[dpfr_pkg::LimitW-1:0];
				else wr_from_q = cfg_data[dpfr_pkg::WrPageW-1:0];
			end
			if (done) begin
				if (pending_q.size() == 0) begin
					report("unexpected result", 1, 0);
				end else begin
					e = pending_q.pop_front();
					checked++;
					if (result.status != e.status) report("status", result.status, e.status);
					if (result.frame != e.frame) report("frame", result.frame, e.frame);
					if (result.offset != e.offset) report("offset", result.offset, e.offset);
					if (result.evicted != e.evicted)
						report("evicted", result.evicted, e.evicted);
					if (result.evicted_page != e.evicted_page)
						report("evicted_page", result.evicted_page, e.evicted_page);
					if (result.writeback != e.writeback)
						report("writeback", result.writeback, e.writeback);
				end
			end
			if (start && !busy) pending_q.push_back(translate(in_word));
		end
		outstanding = pending_q.size();
	end

endmodule

// ===== bench/tb.sv =====
// testbench top for the demand paging fifo replacement unit
// drives accesses and register writes; depends on dpfr_pkg, dpfr_checker and demand_paging_fifo_replacement_unit
module tb;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	dpfr_pkg::in_word_t            in_word;
	logic                          done;
	dpfr_pkg::out_word_t           result;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [dpfr_pkg::CfgIdxW-1:0]  cfg_index;
	logic [dpfr_pkg::CfgDataW-1:0] cfg_data;
	int                            errors;
	int                            outstanding;
	int                            checked;
	int                            n_sent;
	int                            n_cfg;
	int                            idle_pct;
	int                            page_base;

	demand_paging_fifo_replacement_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_word(in_word),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	dpfr_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_word(in_word),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .errors(errors),
		.outstanding(outstanding), .checked(checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard limit on run length
	initial begin
		#4000000;
		$display("tb failed");
		$finish;
	end

	// present one access word, holding it until the unit takes it
	task automatic access(input logic act, input logic [15:0] va);
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		start   <= 1'b1;
		in_word <= '{action: act, vaddr: va};
		while (busy) @(negedge clk);
		@(negedge clk);
		n_sent++;
	endtask

	// sender holds off until every outstanding result is back, plus pipeline depth
	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// register write, only issued with the unit drained
	task automatic write_reg(input dpfr_pkg::reg_idx_t idx, input int val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= dpfr_pkg::CfgDataW'(val);
		while (!cfg_ready) @(negedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		n_cfg++;
	endtask

	// mostly a small working set of pages so hits, evictions and swap fills recur
	task automatic random_access();
		int r;
		logic [15:0] va;
		r = $urandom_range(0, 99);
		if (r < 75) va = 16'(((page_base + $urandom_range(0, 13)) % 64) * 16
			+ $urandom_range(0, 15));
		else if (r < 90) va = 16'($urandom_range(0, 1023));
		else va = 16'($urandom);
		access(1'($urandom), va);
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		in_word   = '0;
		cfg_valid = 1'b0;
		cfg_index = dpfr_pkg::REG_EXEC_LIMIT;
		cfg_data  = '0;
		n_sent    = 0;
		n_cfg     = 0;
		idle_pct  = 0;
		page_base = 30;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: range edges, read-only store, fills up to eviction, swap refill
		access(1'b0, 16'd1023);
		access(1'b0, 16'd1024);
		access(1'b1, 16'hFFFF);
		access(1'b1, 16'd0);
		access(1'b0, 16'd0);
		access(1'b1, 16'd511);
		access(1'b1, 16'd512);
		for (int p = 33; p < 40; p++) access(1'b1, 16'(p * 16 + 5));
		access(1'b0, 16'd512);
		access(1'b0, 16'd800);
		access(1'b0, 16'd528);
		access(1'b0, 16'd512);
		access(1'b1, 16'h8000);
		// exec_limit zero refuses all, widest limit cuts at the page count
		write_reg(dpfr_pkg::REG_EXEC_LIMIT, 0);
		write_reg(dpfr_pkg::REG_WR_FROM, 64);
		access(1'b0, 16'd0);
		access(1'b1, 16'd700);
		write_reg(dpfr_pkg::REG_EXEC_LIMIT, 2047);
		access(1'b0, 16'd1030);
		access(1'b1, 16'd1023);
		write_reg(dpfr_pkg::REG_WR_FROM, 0);
		access(1'b1, 16'd3);

		// random phases with different register settings and idling
		write_reg(dpfr_pkg::REG_EXEC_LIMIT, 1024);
		write_reg(dpfr_pkg::REG_WR_FROM, 32);
		idle_pct = 20;
		for (int i = 0; i < 150; i++) random_access();
		write_reg(dpfr_pkg::REG_EXEC_LIMIT, 700);
		write_reg(dpfr_pkg::REG_WR_FROM, 0);
		idle_pct  = 47;
		page_base = 5;
		for (int i = 0; i < 150; i++) random_access();
		write_reg(dpfr_pkg::REG_EXEC_LIMIT, 1024);
		write_reg(dpfr_pkg::REG_WR_FROM, 10);
		idle_pct  = 0;
		page_base = 50;
		for (int i = 0; i < 150; i++) random_access();

		drain();
		$display("covered %0d accesses across %0d register writes", n_sent, n_cfg);
		$display("%0d results compared, %0d mismatches", checked, errors);
		if (errors == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/dpfr_pkg.sv
hdl/dpfr_front.sv
hdl/dpfr_queue.sv
hdl/dpfr_back.sv
hdl/demand_paging_fifo_replacement_unit.sv
bench/dpfr_checker.sv
bench/tb.sv
